/* rtl/cir_pkg.sv */
// Shared widths, constants and saturation helpers for the contact impulse resolver.
package cir_pkg;

  localparam int unsigned VEL_W  = 32;
  localparam int unsigned MASS_W = 32;
  localparam int unsigned NRM_W  = 16;
  localparam int unsigned RST_W  = 16;
  localparam int unsigned FAC_W  = 17;
  localparam int unsigned QMAG_W = 48;
  localparam int unsigned IN_DATA_W  = 272;
  localparam int unsigned OUT_DATA_W = 128;

  localparam logic [31:0]      ITS_RESET = 32'd3932160;
  localparam logic [FAC_W-1:0] FAC_ONE   = 17'd32768;

  typedef struct packed {
    logic                    line;
    logic signed [VEL_W-1:0] vax;
    logic signed [VEL_W-1:0] vay;
    logic signed [VEL_W-1:0] vbx;
    logic signed [VEL_W-1:0] vby;
    logic [MASS_W-1:0]       ma;
    logic [MASS_W-1:0]       mb;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
  } ctx_t;

  // {flag, value}
  function automatic logic [32:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (x < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, x[31:0]};
  endfunction

  // signed quotient from magnitude and sign, clamped to 32 bits: {flag, value}
  function automatic logic [32:0] sat_quo(input logic [QMAG_W-1:0] mag, input logic neg);
    logic [QMAG_W-1:0] negm;
    negm = ~mag + QMAG_W'(1);
    if (neg) begin
      if (mag > QMAG_W'(64'h8000_0000)) return {1'b1, 32'h8000_0000};
      return {1'b0, negm[31:0]};
    end
    if (mag > QMAG_W'(64'h7FFF_FFFF)) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, mag[31:0]};
  endfunction

endpackage

/* rtl/cir_udiv.sv */
// Pipelined restoring unsigned divider, one quotient bit per stage, with sideband.
module cir_udiv #(
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned QUO_W  = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DEN_W-1:0]  rem_i,   // upper dividend bits, below den_i
  input  logic [QUO_W-1:0]  num_i,   // dividend bits that become quotient bits
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [QUO_W];
  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  acc_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [QUO_W-1:0]  acc_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = rem_i;
      assign acc_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign acc_in  = acc_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, acc_in[QUO_W-1]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
        if (trial >= {1'b0, den_in}) begin
          rem_q[k] <= diff[DEN_W-1:0];
          acc_q[k] <= {acc_in[QUO_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= trial[DEN_W-1:0];
          acc_q[k] <= {acc_in[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = acc_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

/* rtl/contact_impulse_resolver_top.sv */
// Contact impulse resolver: pipelined normal impulse with restitution and depth bias.
//
//  channel   | direction | fields
//  s_axis    | in        | tdata: velocities, masses, normal, depth, restitution; tuser: mode
//  m_axis    | out       | tdata: four new velocities; tuser: saturated
//  cfg       | in        | inverse_time_step, written when cfg_we_i is high
//
// One beat per cycle while no finished beat waits at m_axis; beats pass through the 32-stage
// reduced-mass divider and the 48-stage impulse dividers.
// rst_ni clears all valid bits and loads inverse_time_step with 60.0.
// The whole pipeline holds while a finished beat waits at m_axis.
module contact_impulse_resolver_top
  import cir_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [31:0]           cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // vel_a_x, vel_a_y, vel_b_x, vel_b_y, mass_a, mass_b, normal_x, normal_y, depth, restitution
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // saturated
  output logic                  m_axis_tuser
);

  localparam int unsigned SD1_W = $bits(ctx_t) + 33;
  localparam int unsigned SD2_W = $bits(ctx_t) + 1;

  logic en;
  logic [31:0] its_q;

  // stage regs
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, vo_q;
  ctx_t c1_q, c2_q, c3_q, c4_q, c5_q, c6_q, c7_q, c8_q, c9_q;
  ctx_t c1_d;
  logic [FAC_W-1:0] fac1_q, fac2_q, fac3_q;
  logic signed [32:0] dvx1_q, dvy1_q;
  logic signed [63:0] kd1_q;
  logic [63:0] mm1_q, mm2_q, mm3_q, mm4_q, mm5_q;
  logic signed [48:0] pxn2_q, pyn2_q;
  logic [31:0] bias2_q, bias3_q, bias4_q, vn3_q;
  logic f2_q, f3_q, f4_q, f5_q, f6_q, f7_q, f8_q, f9_q;
  logic sep4_q;
  logic signed [51:0] prod4_q;
  logic [31:0] term5_q;
  logic signed [63:0] prod6_q;
  logic [31:0] cval7_q, qa8_q, qb8_q;
  logic signed [47:0] pax9_q, pay9_q, pbx9_q, pby9_q;
  logic [OUT_DATA_W-1:0] tdata_q;
  logic tuser_q;

  assign en = !vo_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      its_q <= ITS_RESET;
    end else if (cfg_we_i) begin
      its_q <= cfg_wdata_i;
    end
  end

  // stage 1: differences, bias and mass products
  always_comb begin
    c1_d.line = s_axis_tuser;
    c1_d.vax  = $signed(s_axis_tdata[31:0]);
    c1_d.vay  = $signed(s_axis_tdata[63:32]);
    c1_d.vbx  = $signed(s_axis_tdata[95:64]);
    c1_d.vby  = $signed(s_axis_tdata[127:96]);
    c1_d.ma   = s_axis_tdata[159:128];
    c1_d.mb   = s_axis_tdata[191:160];
    c1_d.nx   = $signed(s_axis_tdata[207:192]);
    c1_d.ny   = $signed(s_axis_tdata[223:208]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q   <= c1_d;
      fac1_q <= {1'b0, s_axis_tdata[271:256]} + FAC_ONE;
      dvx1_q <= 33'(c1_d.vbx) - 33'(c1_d.vax);
      dvy1_q <= 33'(c1_d.vby) - 33'(c1_d.vay);
      kd1_q  <= $signed({1'b0, its_q}) * $signed(s_axis_tdata[255:224]);
      mm1_q  <= c1_d.ma * c1_d.mb;
    end
  end

  // stage 2: normal projection products, bias
  logic signed [63:0] bias_sh;
  logic [32:0] bias_s;
  always_comb begin
    bias_sh = kd1_q >>> 16;
    bias_s  = sat32(bias_sh);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q    <= c1_q;
      fac2_q  <= fac1_q;
      mm2_q   <= mm1_q;
      pxn2_q  <= dvx1_q * c1_q.nx;
      pyn2_q  <= dvy1_q * c1_q.ny;
      bias2_q <= bias_s[31:0];
      f2_q    <= bias_s[32];
    end
  end

  // stage 3: vn
  logic signed [49:0] vsum;
  logic signed [63:0] vsum_sh;
  logic [32:0] vn_s;
  always_comb begin
    vsum    = 50'(pxn2_q) + 50'(pyn2_q);
    vsum_sh = 64'(vsum) >>> 14;
    vn_s    = sat32(vsum_sh);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_q    <= c2_q;
      fac3_q  <= fac2_q;
      mm3_q   <= mm2_q;
      bias3_q <= bias2_q;
      vn3_q   <= vn_s[31:0];
      f3_q    <= f2_q | vn_s[32];
    end
  end

  // stage 4: restitution product
  logic signed [33:0] vn34, b34, x4;
  logic sep;
  always_comb begin
    vn34 = 34'($signed(vn3_q));
    b34  = 34'($signed(bias3_q));
    sep  = $signed(vn3_q) > 32'sd0;
    if (!c3_q.line) begin
      x4 = vn34;
    end else if (sep) begin
      x4 = -b34;
    end else begin
      x4 = vn34 - b34;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_q    <= c3_q;
      mm4_q   <= mm3_q;
      bias4_q <= bias3_q;
      sep4_q  <= sep && !c3_q.line;
      prod4_q <= $signed({1'b0, fac3_q}) * x4;
      f4_q    <= f3_q;
    end
  end

  // stage 5: term
  logic signed [63:0] p64, b64, t64;
  logic [32:0] term_s;
  always_comb begin
    p64 = 64'(prod4_q) >>> 15;
    b64 = 64'($signed(bias4_q));
    if (sep4_q) begin
      t64 = -b64;
    end else if (!c4_q.line) begin
      t64 = p64 - b64;
    end else begin
      t64 = p64;
    end
    term_s = sat32(t64);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c5_q    <= c4_q;
      mm5_q   <= mm4_q;
      term5_q <= term_s[31:0];
      f5_q    <= f4_q | term_s[32];
    end
  end

  // reduced mass divider
  logic              vda;
  logic [31:0]       quo_s;
  logic [SD1_W-1:0]  sd1_o;
  ctx_t              cda;
  logic [31:0]       term_da;
  logic              f_da;

  cir_udiv #(
    .DEN_W (33),
    .QUO_W (32),
    .SIDE_W(SD1_W)
  ) u_div_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v5_q),
    .rem_i  ({1'b0, mm5_q[63:32]}),
    .num_i  (mm5_q[31:0]),
    .den_i  ({1'b0, c5_q.ma} + {1'b0, c5_q.mb}),
    .side_i ({c5_q, term5_q, f5_q}),
    .valid_o(vda),
    .quo_o  (quo_s),
    .side_o (sd1_o)
  );

  assign {cda, term_da, f_da} = sd1_o;

  // stage 6: impulse product
  logic [31:0] scale;
  always_comb begin
    if (cda.line) begin
      scale = cda.ma >> 1;
    end else if (cda.ma == '0 && cda.mb == '0) begin
      scale = '0;
    end else begin
      scale = quo_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c6_q    <= cda;
      prod6_q <= $signed({1'b0, scale}) * $signed(term_da);
      f6_q    <= f_da;
    end
  end

  // stage 7: c
  logic signed [63:0] c64;
  logic [32:0] c_s;
  always_comb begin
    c64 = prod6_q >>> 16;
    c_s = sat32(c64);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c7_q    <= c6_q;
      cval7_q <= c_s[31:0];
      f7_q    <= f6_q | c_s[32];
    end
  end

  // per-body quotient dividers on |c| * 2^16
  logic [31:0] cmag;
  logic [QMAG_W-1:0] cnum;
  assign cmag = cval7_q[31] ? (~cval7_q + 32'd1) : cval7_q;
  assign cnum = {cmag, 16'h0000};

  logic vqa, vqb;
  logic [QMAG_W-1:0] qa_mag, qb_mag;
  logic [SD2_W-1:0] sd2_o;
  logic cneg_b;
  ctx_t cqa;
  logic f_qa;

  cir_udiv #(
    .DEN_W (MASS_W),
    .QUO_W (QMAG_W),
    .SIDE_W(SD2_W)
  ) u_div_qa (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v7_q),
    .rem_i  ('0),
    .num_i  (cnum),
    .den_i  (c7_q.ma),
    .side_i ({c7_q, f7_q}),
    .valid_o(vqa),
    .quo_o  (qa_mag),
    .side_o (sd2_o)
  );

  cir_udiv #(
    .DEN_W (MASS_W),
    .QUO_W (QMAG_W),
    .SIDE_W(1)
  ) u_div_qb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v7_q),
    .rem_i  ('0),
    .num_i  (cnum),
    .den_i  (c7_q.mb),
    .side_i (cval7_q[31]),
    .valid_o(vqb),
    .quo_o  (qb_mag),
    .side_o (cneg_b)
  );

  assign {cqa, f_qa} = sd2_o;

  // stage 8: signed, clamped quotients
  logic [32:0] qa_s, qb_s;
  always_comb begin
    qa_s = (cqa.ma == '0) ? 33'd0 : sat_quo(qa_mag, cneg_b);
    qb_s = (cqa.mb == '0) ? 33'd0 : sat_quo(qb_mag, !cneg_b);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c8_q  <= cqa;
      qa8_q <= qa_s[31:0];
      qb8_q <= qb_s[31:0];
      f8_q  <= f_qa | qa_s[32] | qb_s[32];
    end
  end

  // stage 9: velocity deltas
  always_ff @(posedge clk_i) begin
    if (en) begin
      c9_q   <= c8_q;
      pax9_q <= c8_q.nx * $signed(qa8_q);
      pay9_q <= c8_q.ny * $signed(qa8_q);
      pbx9_q <= c8_q.nx * $signed(qb8_q);
      pby9_q <= c8_q.ny * $signed(qb8_q);
      f9_q   <= f8_q;
    end
  end

  // output stage
  logic [32:0] nax_s, nay_s, nbx_s, nby_s;
  always_comb begin
    nax_s = sat32(64'(c9_q.vax) + (64'(pax9_q) >>> 14));
    nay_s = sat32(64'(c9_q.vay) + (64'(pay9_q) >>> 14));
    nbx_s = sat32(64'(c9_q.vbx) + (64'(pbx9_q) >>> 14));
    nby_s = sat32(64'(c9_q.vby) + (64'(pby9_q) >>> 14));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= {nby_s[31:0], nbx_s[31:0], nay_s[31:0], nax_s[31:0]};
      tuser_q <= f9_q | nax_s[32] | nay_s[32] | nbx_s[32] | nby_s[32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= vda;
      v7_q <= v6_q;
      v8_q <= vqa;
      v9_q <= v8_q;
      vo_q <= v9_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni) vqa == vqb)
    else $error("impulse dividers out of step");

  a_stall_only_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no beat pending");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule
